>>> src/vfv_pkg.sv
// vfv_pkg: shared widths, codes and types for the voxel face visibility block.
// No dependencies; imported by vfv_ctrl and voxel_face_visibility.
package vfv_pkg;

  localparam int COORD_W    = 4;
  localparam int NEW_ID_W   = 16;
  localparam int CELL_ID_W  = 16;
  localparam int FACE_TOTAL = 6;
  localparam int FACE_CNT_W = 3;

  // packed stream widths: fields low to high, padded to whole bytes
  localparam int IN_FIELDS_W  = 3 * COORD_W + NEW_ID_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = CELL_ID_W + FACE_TOTAL + FACE_CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  // read sequence of a query: the cell itself, then the faces in mask order
  typedef enum logic [2:0] {
    SEQ_CENTRE = 3'd0,
    SEQ_PX     = 3'd1,
    SEQ_NX     = 3'd2,
    SEQ_PY     = 3'd3,
    SEQ_NY     = 3'd4,
    SEQ_PZ     = 3'd5,
    SEQ_NZ     = 3'd6
  } seq_step_t;

endpackage

>>> src/vfv_grid_mem.sv
// vfv_grid_mem: single-port synchronous grid memory, read data registered.
// No dependencies; instantiated by voxel_face_visibility.
module vfv_grid_mem #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/vfv_ctrl.sv
// vfv_ctrl: item sequencer - clear pass, cell writes, seven-read face query
// and the result register. Depends on vfv_pkg; drives vfv_grid_mem.
module vfv_ctrl
  import vfv_pkg::*;
#(
  parameter int GRID_WIDTH  = 16,
  parameter int GRID_HEIGHT = 16,
  parameter int GRID_LENGTH = 16,
  parameter int ID_BITS     = 16,
  parameter int XB          = 4,
  parameter int YB          = 4,
  parameter int ZB          = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // item side
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   item_mode,
  input  logic [COORD_W-1:0]     item_x,
  input  logic [COORD_W-1:0]     item_y,
  input  logic [COORD_W-1:0]     item_z,
  input  logic [NEW_ID_W-1:0]    item_new_id,
  // result side
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [CELL_ID_W-1:0]   res_cell_id,
  output logic [FACE_TOTAL-1:0]  res_face_mask,
  output logic [FACE_CNT_W-1:0]  res_face_count,
  // grid memory
  output logic                   mem_we,
  output logic [XB+YB+ZB-1:0]    mem_addr,
  output logic [ID_BITS-1:0]     mem_wdata,
  input  logic [ID_BITS-1:0]     mem_rdata
);

  localparam int AW  = XB + YB + ZB;
  localparam int EXT = 9;   // holds any grid size up to 256 and coordinate + 1

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_FINISH,
    ST_HOLD
  } state_t;

  state_t                state_r;
  logic [AW-1:0]         clr_cnt_r;
  logic [COORD_W-1:0]    x_r, y_r, z_r;
  logic [NEW_ID_W-1:0]   new_id_r;
  seq_step_t             step_r;
  logic                  pend_r;
  seq_step_t             pend_step_r;
  logic                  pend_open_r;
  logic [ID_BITS-1:0]    id_r;
  logic [FACE_TOTAL-1:0] mask_r;
  logic                  out_valid_r;
  logic [CELL_ID_W-1:0]  out_id_r;
  logic [FACE_TOTAL-1:0] out_mask_r;
  logic [FACE_CNT_W-1:0] out_count_r;

  logic [EXT-1:0]        x9, y9, z9, nx9, ny9, nz9;
  logic                  nb_ok;
  logic                  cur_in_grid;
  logic                  item_in_grid;
  logic [AW-1:0]         centre_addr, nb_addr;
  logic [FACE_TOTAL-1:0] final_mask;
  logic [FACE_CNT_W-1:0] final_count;
  logic                  accept;

  assign accept     = item_valid && item_ready;
  assign item_ready = (state_r == ST_IDLE);

  assign item_in_grid = ({5'b0, item_x} < EXT'(GRID_WIDTH)) &&
                        ({5'b0, item_y} < EXT'(GRID_HEIGHT)) &&
                        ({5'b0, item_z} < EXT'(GRID_LENGTH));

  assign x9 = {5'b0, x_r};
  assign y9 = {5'b0, y_r};
  assign z9 = {5'b0, z_r};

  assign cur_in_grid = (x9 < EXT'(GRID_WIDTH)) && (y9 < EXT'(GRID_HEIGHT)) &&
                       (z9 < EXT'(GRID_LENGTH));

  assign centre_addr = {x9[XB-1:0], y9[YB-1:0], z9[ZB-1:0]};

  // neighbour of the current step; the cell itself is known to be inside
  always_comb begin
    nx9   = x9;
    ny9   = y9;
    nz9   = z9;
    nb_ok = 1'b1;
    unique case (step_r)
      SEQ_CENTRE: nb_ok = 1'b1;
      SEQ_PX: begin
        nx9   = x9 + EXT'(1);
        nb_ok = nx9 < EXT'(GRID_WIDTH);
      end
      SEQ_NX: begin
        nx9   = x9 - EXT'(1);
        nb_ok = (x9 != '0);
      end
      SEQ_PY: begin
        ny9   = y9 + EXT'(1);
        nb_ok = ny9 < EXT'(GRID_HEIGHT);
      end
      SEQ_NY: begin
        ny9   = y9 - EXT'(1);
        nb_ok = (y9 != '0);
      end
      SEQ_PZ: begin
        nz9   = z9 + EXT'(1);
        nb_ok = nz9 < EXT'(GRID_LENGTH);
      end
      SEQ_NZ: begin
        nz9   = z9 - EXT'(1);
        nb_ok = (z9 != '0);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign nb_addr = {nx9[XB-1:0], ny9[YB-1:0], nz9[ZB-1:0]};

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = nb_addr;
    mem_wdata = ID_BITS'(new_id_r);
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = '0;
      end
      ST_WRITE: begin
        mem_we   = cur_in_grid;
        mem_addr = centre_addr;
      end
      default: mem_addr = nb_addr;
    endcase
  end

  // an empty cell shows no faces
  always_comb begin
    final_mask  = (id_r != '0) ? mask_r : '0;
    final_count = '0;
    for (int i = 0; i < FACE_TOTAL; i++) begin
      final_count = final_count + FACE_CNT_W'(final_mask[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      step_r      <= SEQ_CENTRE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // the hold state reloads the output register itself
      if (out_valid_r && res_ready && state_r != ST_HOLD) begin
        out_valid_r <= 1'b0;
      end

      // read data of the previous step lands here
      pend_r <= (state_r == ST_READ);
      if (pend_r) begin
        if (pend_step_r == SEQ_CENTRE) begin
          id_r <= mem_rdata;
        end else begin
          mask_r[3'(pend_step_r) - 3'd1] <= pend_open_r || (mem_rdata == '0);
        end
      end

      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            x_r      <= item_x;
            y_r      <= item_y;
            z_r      <= item_z;
            new_id_r <= item_new_id;
            step_r   <= SEQ_CENTRE;
            if (item_mode == MODE_WRITE) begin
              state_r <= ST_WRITE;
            end else if (item_in_grid) begin
              state_r <= ST_READ;
            end else begin
              id_r    <= '0;
              state_r <= ST_HOLD;
            end
          end
        end
        ST_WRITE: state_r <= ST_IDLE;
        ST_READ: begin
          pend_step_r <= step_r;
          pend_open_r <= !nb_ok;
          if (step_r == SEQ_NZ) begin
            state_r <= ST_FINISH;
          end else begin
            step_r <= seq_step_t'(3'(step_r) + 3'd1);
          end
        end
        ST_FINISH: state_r <= ST_HOLD;
        ST_HOLD: begin
          if (!out_valid_r || res_ready) begin
            out_valid_r <= 1'b1;
            out_id_r    <= CELL_ID_W'(id_r);
            out_mask_r  <= final_mask;
            out_count_r <= final_count;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign res_valid      = out_valid_r;
  assign res_cell_id    = out_id_r;
  assign res_face_mask  = out_mask_r;
  assign res_face_count = out_count_r;

endmodule

>>> src/voxel_face_visibility.sv
// voxel_face_visibility: top level - stream ports, grid memory and sequencer.
// Depends on vfv_pkg, vfv_grid_mem and vfv_ctrl.
//
//  channel | dir | words carried
//  in_     | in  | one write or query per word, tuser selects which
//  out_    | out | one result word per query, none for writes
//
// A write passes through a single write state after acceptance; a query inside
// the grid makes seven reads through the single grid memory port, then a
// finish state. A query outside the grid goes straight to its result. After
// reset a clearing pass zeroes every memory address, with in_tready low. A
// finished result waits in the output register; the next word is taken
// meanwhile and stalls only when its own result is due.
module voxel_face_visibility
  import vfv_pkg::*;
#(
  parameter int GRID_WIDTH  = 16,
  parameter int GRID_HEIGHT = 16,
  parameter int GRID_LENGTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // cell_x, cell_y, cell_z, new_id, pad
  input  logic                   in_tuser,   // mode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // cell_id, face_mask, face_count, pad
);

  localparam int XB = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
  localparam int YB = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int ZB = (GRID_LENGTH > 1) ? $clog2(GRID_LENGTH) : 1;
  localparam int AW = XB + YB + ZB;
  localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [ID_BITS-1:0]    mem_wdata;
  logic [ID_BITS-1:0]    mem_rdata;
  logic [CELL_ID_W-1:0]  res_cell_id;
  logic [FACE_TOTAL-1:0] res_face_mask;
  logic [FACE_CNT_W-1:0] res_face_count;

  vfv_grid_mem #(
    .ADDR_W (AW),
    .DATA_W (ID_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  vfv_ctrl #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .GRID_LENGTH (GRID_LENGTH),
    .ID_BITS     (ID_BITS),
    .XB          (XB),
    .YB          (YB),
    .ZB          (ZB)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (in_tvalid),
    .item_ready     (in_tready),
    .item_mode      (in_tuser),
    .item_x         (in_tdata[COORD_W-1:0]),
    .item_y         (in_tdata[2*COORD_W-1:COORD_W]),
    .item_z         (in_tdata[3*COORD_W-1:2*COORD_W]),
    .item_new_id    (in_tdata[3*COORD_W+NEW_ID_W-1:3*COORD_W]),
    .res_valid      (out_tvalid),
    .res_ready      (out_tready),
    .res_cell_id    (res_cell_id),
    .res_face_mask  (res_face_mask),
    .res_face_count (res_face_count),
    .mem_we         (mem_we),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata),
    .mem_rdata      (mem_rdata)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_face_count, res_face_mask, res_cell_id};

endmodule
